[design/bpl_pkg.sv]
// ----------------------------------------------------------------------------
// bpl_pkg: shared definitions for the bounded positional list
// Sizes, operation and status codes, cell command and request/response types.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    // Entry count can reach CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing the 6-bit position against counts and indexes.
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_POP    = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    // How the row of cells moves when it is updated.
    typedef enum logic [1:0] {
        MODE_HOLD     = 2'd0,  // nothing moves
        MODE_INS      = 2'd1,  // load at pos, cells above take their lower neighbor
        MODE_INS_DROP = 2'd2,  // load at pos, cells below take their upper neighbor
        MODE_ERASE    = 2'd3   // cells from pos upward take their upper neighbor
    } mode_t;

    typedef struct packed {
        mode_t mode;
        cmp_t  pos;
        logic  rd_en;
        cmp_t  rd_pos;
    } cell_cmd_t;

    typedef struct packed {
        op_t         operation;
        logic [5:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [5:0]  entry_count;
        status_t     status;
    } rsp_t;

endpackage

[design/bpl_cell.sv]
// ----------------------------------------------------------------------------
// bpl_cell: one storage cell of the list
// Holds one entry and picks its next value from itself, a neighbor or the
// incoming word; drives its entry onto the read bus when addressed.
// ----------------------------------------------------------------------------
module bpl_cell (
    input  logic                clk,
    input  bpl_pkg::cmp_t       idx,
    input  bpl_pkg::cell_cmd_t  cmd,
    input  logic                update,
    input  bpl_pkg::word_t      load_word,
    input  bpl_pkg::word_t      lower_word,
    input  bpl_pkg::word_t      upper_word,
    output bpl_pkg::word_t      word,
    output bpl_pkg::word_t      rd_word
);

    bpl_pkg::word_t word_reg;
    bpl_pkg::word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.mode)
            bpl_pkg::MODE_HOLD:
            begin
                word_next = word_reg;
            end
            bpl_pkg::MODE_INS:
            begin
                if (idx == cmd.pos)
                    word_next = load_word;
                else if (idx > cmd.pos)
                    word_next = lower_word;
            end
            bpl_pkg::MODE_INS_DROP:
            begin
                if (idx == cmd.pos)
                    word_next = load_word;
                else if (idx < cmd.pos)
                    word_next = upper_word;
            end
            bpl_pkg::MODE_ERASE:
            begin
                if (idx >= cmd.pos)
                    word_next = upper_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (update)
            word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (cmd.rd_en && (idx == cmd.rd_pos)) ? word_reg : '0;

endmodule

[design/bpl_ctrl.sv]
// ----------------------------------------------------------------------------
// bpl_ctrl: request decoder for the list
// Checks the request against the current count and produces the cell
// command, the status code and the count after the operation.
// ----------------------------------------------------------------------------
module bpl_ctrl (
    input  bpl_pkg::req_t       req,
    input  bpl_pkg::cnt_t       count,
    output bpl_pkg::cell_cmd_t  cmd,
    output bpl_pkg::status_t    status,
    output bpl_pkg::cnt_t       count_next
);

    localparam bpl_pkg::cmp_t LAST_IDX = bpl_pkg::cmp_t'(bpl_pkg::CAPACITY - 1);
    localparam bpl_pkg::cnt_t FULL_CNT = bpl_pkg::cnt_t'(bpl_pkg::CAPACITY);

    bpl_pkg::cmp_t pos_c;
    bpl_pkg::cmp_t cnt_c;
    logic          full;
    logic          empty;

    assign pos_c = bpl_pkg::cmp_t'(req.position);
    assign cnt_c = bpl_pkg::cmp_t'(count);
    assign full  = (count == FULL_CNT);
    assign empty = (count == '0);

    always_comb
    begin
        cmd.mode   = bpl_pkg::MODE_HOLD;
        cmd.pos    = '0;
        cmd.rd_en  = 1'b0;
        cmd.rd_pos = '0;
        status     = bpl_pkg::ST_OK;
        count_next = count;
        unique case (req.operation)
            bpl_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    // Oldest entry goes, the word lands in the top cell.
                    cmd.mode = bpl_pkg::MODE_INS_DROP;
                    cmd.pos  = LAST_IDX;
                    status   = bpl_pkg::ST_DROPPED;
                end
                else
                begin
                    cmd.mode   = bpl_pkg::MODE_INS;
                    cmd.pos    = cnt_c;
                    count_next = count + 1'b1;
                end
            end
            bpl_pkg::OP_INSERT:
            begin
                if (pos_c > cnt_c)
                    status = bpl_pkg::ST_RANGE;
                else if (full)
                begin
                    // After the head is dropped the position is clamped to the
                    // reduced count.
                    cmd.mode = bpl_pkg::MODE_INS_DROP;
                    cmd.pos  = (pos_c > LAST_IDX) ? LAST_IDX : pos_c;
                    status   = bpl_pkg::ST_DROPPED;
                end
                else
                begin
                    cmd.mode   = bpl_pkg::MODE_INS;
                    cmd.pos    = pos_c;
                    count_next = count + 1'b1;
                end
            end
            bpl_pkg::OP_ERASE:
            begin
                if (pos_c >= cnt_c)
                    status = bpl_pkg::ST_RANGE;
                else
                begin
                    cmd.mode   = bpl_pkg::MODE_ERASE;
                    cmd.pos    = pos_c;
                    count_next = count - 1'b1;
                end
            end
            bpl_pkg::OP_POP:
            begin
                if (empty)
                    status = bpl_pkg::ST_EMPTY;
                else
                begin
                    cmd.mode   = bpl_pkg::MODE_ERASE;
                    cmd.rd_en  = 1'b1;
                    count_next = count - 1'b1;
                end
            end
            bpl_pkg::OP_READ:
            begin
                if (empty)
                    status = bpl_pkg::ST_EMPTY;
                else if (pos_c >= cnt_c)
                    status = bpl_pkg::ST_RANGE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = pos_c;
                end
            end
            default:
            begin
                // Unused operation codes leave everything as it is.
                status = bpl_pkg::ST_OK;
            end
        endcase
    end

endmodule

[design/bounded_positional_list.sv]
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered list of data words with positional access
// Top level: request decoder, a row of storage cells and the response register.
// ----------------------------------------------------------------------------
//
// The list holds up to CAPACITY words, position 0 being the oldest. Every
// request (push, insert, erase, pop or read) gives one response, and a
// request can be accepted in every cycle while the response side keeps up.
// Each entry lives in its own cell, and a shift of the list is every cell
// taking its neighbor's word on the same clock edge. The response register
// decouples the two sides: req_stall is high only while a finished response
// waits and rsp_stall is high. A push or insert on a full list drops the
// oldest entry and reports it in the status; rejected requests leave the
// list untouched.
//
module bounded_positional_list (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bpl_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bpl_pkg::rsp_t   rsp
);

    bpl_pkg::cell_cmd_t cmd;
    bpl_pkg::status_t   status;
    bpl_pkg::cnt_t      count_reg;
    bpl_pkg::cnt_t      count_next;
    bpl_pkg::word_t     load_word;
    bpl_pkg::word_t     words    [bpl_pkg::CAPACITY];
    bpl_pkg::word_t     rd_words [bpl_pkg::CAPACITY];
    bpl_pkg::word_t     rd_word;
    logic               accept;
    logic               rsp_valid_reg;
    bpl_pkg::rsp_t      rsp_reg;

    // A request is taken whenever the response register is free or is being
    // emptied in this same cycle.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // The data word is taken in its low DATA_WIDTH bits.
    assign load_word = bpl_pkg::word_t'(req.value);

    bpl_ctrl u_ctrl (
        .req        (req),
        .count      (count_reg),
        .cmd        (cmd),
        .status     (status),
        .count_next (count_next)
    );

    // The row of cells. The ends have no neighbor on one side; what they see
    // there only reaches cells beyond the count, which are never read.
    for (genvar i = 0; i < bpl_pkg::CAPACITY; i++)
    begin : g_cell
        bpl_pkg::word_t lower_word;
        bpl_pkg::word_t upper_word;

        if (i == 0)
        begin : g_first
            assign lower_word = load_word;
        end
        else
        begin : g_inner_lo
            assign lower_word = words[i-1];
        end

        if (i == bpl_pkg::CAPACITY - 1)
        begin : g_last
            assign upper_word = load_word;
        end
        else
        begin : g_inner_hi
            assign upper_word = words[i+1];
        end

        bpl_cell u_cell (
            .clk        (clk),
            .idx        (bpl_pkg::cmp_t'(i)),
            .cmd        (cmd),
            .update     (accept),
            .load_word  (load_word),
            .lower_word (lower_word),
            .upper_word (upper_word),
            .word       (words[i]),
            .rd_word    (rd_words[i])
        );
    end

    // At most one cell drives a nonzero word, so the read bus is an OR.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < bpl_pkg::CAPACITY; i++)
            rd_word = rd_word | rd_words[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.read_data   <= 32'(rd_word);
            rsp_reg.entry_count <= 6'(count_next);
            rsp_reg.status      <= status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/bpl_list_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpl_list_checker: response checker for the bounded positional list
// Watches both channels. Each accepted request updates a private copy of the
// list and queues the response it should give. Each accepted response is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module bpl_list_checker
    import bpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_stall,
    input  req_t  req,
    input  logic  rsp_valid,
    input  logic  rsp_stall,
    input  rsp_t  rsp,
    output int    error_count,
    output int    pending_count
);

    // Private copy of the list, head at index 0.
    word_t list_words_q[$];
    rsp_t  expected_rsp_q[$];

    // Applies one request to the list copy and returns the response it causes.
    function automatic rsp_t apply_list_op(req_t r);
        rsp_t  o;
        int    pos;
        word_t w;
        o        = '0;
        o.status = ST_OK;
        pos      = int'(r.position);
        w        = word_t'(r.value);
        case (r.operation)
            OP_PUSH:
            begin
                if (list_words_q.size() >= CAPACITY)
                begin
                    void'(list_words_q.pop_front());
                    o.status = ST_DROPPED;
                end
                list_words_q.push_back(w);
            end
            OP_INSERT:
            begin
                if (pos > list_words_q.size())
                    o.status = ST_RANGE;
                else
                begin
                    if (list_words_q.size() >= CAPACITY)
                    begin
                        void'(list_words_q.pop_front());
                        o.status = ST_DROPPED;
                        if (pos > list_words_q.size())
                            pos = list_words_q.size();
                    end
                    list_words_q.insert(pos, w);
                end
            end
            OP_ERASE:
            begin
                if (pos >= list_words_q.size())
                    o.status = ST_RANGE;
                else
                    list_words_q.delete(pos);
            end
            OP_POP:
            begin
                if (list_words_q.size() == 0)
                    o.status = ST_EMPTY;
                else
                    o.read_data = 32'(list_words_q.pop_front());
            end
            OP_READ:
            begin
                if (list_words_q.size() == 0)
                    o.status = ST_EMPTY;
                else if (pos >= list_words_q.size())
                    o.status = ST_RANGE;
                else
                    o.read_data = 32'(list_words_q[pos]);
            end
            default:
            begin
                // Unassigned operation codes leave the list alone.
            end
        endcase
        o.entry_count = 6'(list_words_q.size());
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(apply_list_op(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response accepted with no request outstanding");
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                        error_count = error_count + 1;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        error_count = error_count + 1;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        error_count = error_count + 1;
                    end
                end
            end
            pending_count = expected_rsp_q.size();
        end
    end

endmodule

[tb/sv/tb_bounded_positional_list.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_positional_list: testbench for the bounded positional list
// Drives a short directed sequence through the empty, partly filled and
// emptied list, then several hundred random requests in phases that fill,
// churn and drain it, with random stalls on both channels. A separate
// checker predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_bounded_positional_list;

    import bpl_pkg::*;

    // Operation codes that the block has no meaning for.
    localparam logic [2:0] OP_IGNORED_LO = 3'd5;
    localparam logic [2:0] OP_IGNORED_HI = 3'd7;

    localparam int IDLE_PCT      = 20;    // chance of an idle cycle on either side
    localparam int HOLD_CYCLES   = 100;   // long receiver hold-off
    localparam int DRAIN_CYCLES  = 16;    // settle time after the last response
    localparam int STUCK_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int RESET_CYCLES  = 11;
    localparam int SEGMENTS      = 13;
    localparam int SEG_ITEMS     = 50;

    // Request mix for one random segment.
    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int error_count;
    int pending_count;

    // Shared between the request driver and the receiver process.
    bit no_idle      = 1'b0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int stuck_cycles = 0;

    wire req_fire = req_valid && !req_stall;
    wire rsp_fire = rsp_valid && !rsp_stall;

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bounded_positional_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bpl_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Response side. It stalls at random, not at all while no_idle is set,
    // and for a long counted stretch whenever the driver bumps hold_trigger.
    // During that stretch the single response register fills and the block
    // has to push back on the request side.
    always @(negedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (no_idle)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: any handshake restarts the count. A correct run never goes
    // anywhere near the limit, even through the long hold-off.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || req_fire || rsp_fire)
                stuck_cycles = 0;
            else
                stuck_cycles = stuck_cycles + 1;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic req_t make_req(op_t op, int pos, logic [31:0] val);
        req_t r;
        r.operation = op;
        r.position  = 6'(pos);
        r.value     = val;
        return r;
    endfunction

    // Picks an operation for the given mix. A few percent of every mix are
    // unassigned codes, which must pass through without touching the list.
    function automatic op_t pick_op(traffic_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return op_t'(3'($urandom_range(OP_IGNORED_LO, OP_IGNORED_HI)));
        case (mix)
            MIX_FILL:
                return (r < 50) ? OP_PUSH : (r < 85) ? OP_INSERT :
                       (r < 92) ? OP_READ : (r < 96) ? OP_ERASE : OP_POP;
            MIX_DRAIN:
                return (r < 8) ? OP_PUSH : (r < 13) ? OP_INSERT :
                       (r < 48) ? OP_ERASE : (r < 83) ? OP_POP : OP_READ;
            default:
                return (r < 22) ? OP_PUSH : (r < 42) ? OP_INSERT :
                       (r < 60) ? OP_ERASE : (r < 75) ? OP_POP : OP_READ;
        endcase
    endfunction

    // Positions lean toward the head, where short lists live, and toward
    // the capacity itself, which is the append/clamp point of a full list.
    function automatic int pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CAPACITY;
        if (r < 55)
            return $urandom_range(0, 3);
        return $urandom_range(0, CAPACITY);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return $urandom;
    endfunction

    // Offers one request and returns at the falling edge after it was taken.
    // Entered and left at a falling edge, so valid is either kept high for
    // the next request or lowered for a gap, never both in one step.
    task automatic send_req(req_t r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Stops offering requests until every outstanding response has come back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        traffic_mix_t mix;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: every flagged case on the empty list, inserts at the
        // head, in the middle and at the tail, reads and erases on both sides
        // of the end, the unassigned codes, and popping the list empty again.
        send_req(make_req(OP_READ,   0, '0));             // read of an empty list
        send_req(make_req(OP_POP,    0, '0));             // pop of an empty list
        send_req(make_req(OP_ERASE,  0, '1));             // erase of an empty list
        send_req(make_req(OP_INSERT, 1, 32'h0000_0001));  // insert beyond the count
        send_req(make_req(OP_INSERT, 0, 32'hFFFF_FFFF));
        send_req(make_req(OP_PUSH,   0, 32'h0000_0000));
        send_req(make_req(OP_PUSH,   CAPACITY, 32'hA5A5_5A5A));
        send_req(make_req(OP_INSERT, 3, 32'h5A5A_A5A5));  // position equal to count appends
        send_req(make_req(OP_INSERT, 1, 32'h8000_0001));  // insert in the middle
        send_req(make_req(OP_READ,   0, '0));
        send_req(make_req(OP_READ,   4, '0));             // last entry
        send_req(make_req(OP_READ,   5, '0));             // just past the end
        send_req(make_req(OP_READ,   CAPACITY, '1));
        send_req(make_req(OP_ERASE,  1, '0));
        send_req(make_req(OP_ERASE,  4, '0));             // erase at the count
        send_req(make_req(OP_ERASE,  3, '0));             // erase the tail
        send_req(make_req(op_t'(OP_IGNORED_LO), 0, '1));
        send_req(make_req(op_t'(OP_IGNORED_HI), CAPACITY, '1));
        send_req(make_req(OP_POP,    0, '0));
        send_req(make_req(OP_POP,    0, '0));
        send_req(make_req(OP_POP,    0, '0));
        send_req(make_req(OP_POP,    0, '0));             // pop of the list, now empty again

        // Random part: segments that fill the list past capacity, churn it
        // around full and mid levels, and drain it back to empty, so that the
        // drop-oldest and clamp paths get plenty of traffic.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       mix = MIX_FILL;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            // One segment runs flat out on both sides.
            no_idle = (seg == 3);
            // Once the sender waits for every response before going on.
            if (seg == 8)
                wait_for_drain();
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Once the receiver holds off for a long stretch while the
                // sender keeps offering requests.
                if (seg == 5 && n == 10)
                    hold_trigger = hold_trigger + 1;
                send_req(make_req(pick_op(mix), pick_position(), pick_value()));
            end
        end
        no_idle = 1'b0;

        // All requests are in; wait for the last responses and a little more
        // so that any stray response is still caught.
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/bpl_pkg.sv
design/bpl_cell.sv
design/bpl_ctrl.sv
design/bounded_positional_list.sv
tb/sv/bpl_list_checker.sv
tb/sv/tb_bounded_positional_list.sv
